### src/multidrop_packet_receiver_macros.svh
// ----------------------------------------------------------------------------
// multidrop packet receiver assertion macros
// shared property shorthands for the checker file
// ----------------------------------------------------------------------------
`ifndef MULTIDROP_PACKET_RECEIVER_MACROS_SVH
`define MULTIDROP_PACKET_RECEIVER_MACROS_SVH

// same-cycle implication
`define MPR_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("mpr assertion failed");

// next-cycle implication
`define MPR_ASSERT_NXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("mpr assertion failed");

`endif

### src/mpr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mpr_pkg
// types and codes shared by the multidrop packet receiver modules
// ----------------------------------------------------------------------------
package mpr_pkg;

   // csr register indexes
   localparam int CSR_ADDR_W = 1;
   localparam logic [CSR_ADDR_W-1:0] CSR_DEVICE_ID = 1'b0;
   localparam logic [CSR_ADDR_W-1:0] CSR_RX_ENABLE = 1'b1;

   localparam int REQ_DATA_W = 16;
   localparam int RSP_DATA_W = 24;

   typedef enum logic [2:0] {
      REPLY_NONE   = 3'd0,
      REPLY_ACK    = 3'd1,
      REPLY_NACK   = 3'd2,
      REPLY_EMPTY  = 3'd3,
      REPLY_LAUNCH = 3'd4
   } reply_type;

   typedef enum logic [1:0] {
      KIND_READ   = 2'd0,
      KIND_IGNORE = 2'd1,
      KIND_CHAR   = 2'd2
   } kind_type;

   // classified transaction handed from front to back
   typedef struct packed {
      kind_type   kind;
      logic [7:0] char_data;
      logic       address_bit;
      logic       overrun_error;
      logic       framing_error;
      logic       tx_packet_ready;
      logic       poll_match;
      logic       own_match;
      logic       zero_addr;
   } item_type;

   typedef struct packed {
      reply_type  reply_kind;
      logic       packet_committed;
      logic [7:0] read_data;
      logic       read_valid;
      logic       status_overrun;
      logic       status_framing;
      logic       status_checksum;
      logic       is_broadcast;
   } result_type;

endpackage

### src/mpr_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mpr_ram
// generic single write port ram with registered read
// ----------------------------------------------------------------------------
module mpr_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 128
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### src/mpr_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mpr_front
// accepts request transactions, classifies them and queues them for the back
// ----------------------------------------------------------------------------
module mpr_front (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        in_valid,
   output logic                        in_ready,
   input  logic                        in_operation,
   input  logic [mpr_pkg::REQ_DATA_W-1:0] in_data,
   input  logic [6:0]                  device_id,
   input  logic                        rx_enable,
   output logic                        out_valid,
   input  logic                        out_ready,
   output mpr_pkg::item_type           out_item
);

   import mpr_pkg::*;

   localparam int QUEUE_DEPTH = 2;

   item_type   item_in;
   item_type   entry_ff [QUEUE_DEPTH];
   logic       wr_ptr_ff;
   logic       rd_ptr_ff;
   logic [1:0] count_ff;
   logic [1:0] count_in;
   logic       push;
   logic       pop;

   // classification needs only the transaction and the csr values
   always_comb begin
      item_in.char_data       = in_data[7:0];
      item_in.address_bit     = in_data[8];
      item_in.overrun_error   = in_data[9];
      item_in.framing_error   = in_data[10];
      item_in.tx_packet_ready = in_data[11];
      item_in.poll_match      = (in_data[7:0] == {1'b1, device_id});
      item_in.zero_addr       = (in_data[7:0] == 8'd0);
      item_in.own_match       = (in_data[7:0] == {1'b0, device_id}) || item_in.zero_addr;
      if (in_operation) begin
         item_in.kind = KIND_READ;
      end else if (rx_enable) begin
         item_in.kind = KIND_CHAR;
      end else begin
         item_in.kind = KIND_IGNORE;
      end
   end

   assign in_ready  = (count_ff != 2'(QUEUE_DEPTH));
   assign out_valid = (count_ff != 2'd0);
   assign out_item  = entry_ff[rd_ptr_ff];
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;

   always_comb begin
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 2'd1;
      end else if (pop && !push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         count_ff <= count_in;
         if (push) begin
            wr_ptr_ff <= ~wr_ptr_ff;
         end
         if (pop) begin
            rd_ptr_ff <= ~rd_ptr_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= item_in;
      end
   end

endmodule

### src/mpr_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mpr_back
// packet state machine, ring buffer and result register
// ----------------------------------------------------------------------------
module mpr_back #(
   parameter int RING_DEPTH = 128
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   output logic                 in_ready,
   input  mpr_pkg::item_type    in_item,
   output logic                 out_valid,
   input  logic                 out_ready,
   output mpr_pkg::result_type  out_result
);

   import mpr_pkg::*;

   localparam int IDX_W = $clog2(RING_DEPTH);

   function automatic logic [IDX_W-1:0] wrap_add(input logic [IDX_W-1:0] base,
                                                 input logic [IDX_W:0]   inc);
      logic [IDX_W+1:0] sum;
      sum = {2'b00, base} + {1'b0, inc};
      if (sum >= (IDX_W+2)'(RING_DEPTH)) begin
         sum = sum - (IDX_W+2)'(RING_DEPTH);
      end
      return sum[IDX_W-1:0];
   endfunction

   logic [IDX_W-1:0] commit_ff, commit_in;
   logic [IDX_W-1:0] wr_ff, wr_in;
   logic [IDX_W-1:0] end_ff, end_in;
   logic [IDX_W-1:0] read_ff, read_in;
   logic             len_known_ff, len_known_in;
   logic [7:0]       sum_ff, sum_in;
   logic             addr_wait_ff, addr_wait_in;
   logic             poll_ff, poll_in;
   logic             bcast_ff, bcast_in;
   logic [2:0]       err_ff, err_in;

   logic             s1_valid_ff;
   reply_type        s1_reply_ff, reply_in;
   logic             s1_commit_ff, committed_in;
   logic             s1_rvalid_ff, rvalid_in;
   logic [2:0]       s1_err_ff;
   logic             s1_bcast_ff;

   logic             advance;
   logic             pop;
   logic             ram_we;
   logic [IDX_W-1:0] ram_wa;
   logic [7:0]       ram_q;
   logic [7:0]       sum_new;

   assign advance  = !s1_valid_ff || out_ready;
   assign in_ready = advance;
   assign pop      = in_valid && advance;
   assign sum_new  = sum_ff + in_item.char_data;

   always_comb begin
      commit_in    = commit_ff;
      wr_in        = wr_ff;
      end_in       = end_ff;
      read_in      = read_ff;
      len_known_in = len_known_ff;
      sum_in       = sum_ff;
      addr_wait_in = addr_wait_ff;
      poll_in      = poll_ff;
      bcast_in     = bcast_ff;
      err_in       = err_ff;
      reply_in     = REPLY_NONE;
      committed_in = 1'b0;
      rvalid_in    = 1'b0;
      ram_we       = 1'b0;
      ram_wa       = wr_ff;
      if (pop) begin
         unique case (in_item.kind)
            KIND_READ: begin
               if (read_ff != commit_ff) begin
                  rvalid_in = 1'b1;
                  read_in   = wrap_add(read_ff, (IDX_W+1)'(1));
               end
            end
            KIND_CHAR: begin
               priority if (addr_wait_ff && !in_item.address_bit) begin
                  // data while waiting for an address is dropped unseen
               end else if (in_item.overrun_error) begin
                  err_in[0]    = 1'b1;
                  addr_wait_in = 1'b1;
               end else if (in_item.framing_error) begin
                  err_in[1]    = 1'b1;
                  addr_wait_in = 1'b1;
               end else if (in_item.address_bit) begin
                  priority if (in_item.poll_match) begin
                     poll_in      = 1'b1;
                     addr_wait_in = 1'b0;
                  end else if (in_item.own_match) begin
                     poll_in      = 1'b0;
                     addr_wait_in = 1'b0;
                     bcast_in     = in_item.zero_addr;
                     sum_in       = in_item.char_data;
                     len_known_in = 1'b0;
                     ram_we       = 1'b1;
                     ram_wa       = commit_ff;
                     wr_in        = wrap_add(commit_ff, (IDX_W+1)'(1));
                     end_in       = wrap_add(commit_ff, (IDX_W+1)'(RING_DEPTH - 1));
                  end else begin
                     poll_in      = 1'b0;
                     addr_wait_in = 1'b1;
                  end
               end else if (poll_ff) begin
                  addr_wait_in = 1'b1;
                  if (in_item.poll_match) begin
                     reply_in = in_item.tx_packet_ready ? REPLY_LAUNCH : REPLY_EMPTY;
                  end
               end else begin
                  sum_in = sum_new;
                  priority if (len_known_ff && wr_ff == end_ff) begin
                     // checksum byte closes the packet
                     addr_wait_in = 1'b1;
                     if (sum_new == 8'd0) begin
                        commit_in    = wr_ff;
                        committed_in = 1'b1;
                        reply_in     = bcast_ff ? REPLY_NONE : REPLY_ACK;
                     end else begin
                        err_in[2] = 1'b1;
                        reply_in  = bcast_ff ? REPLY_NONE : REPLY_NACK;
                     end
                  end else if (wr_ff == read_ff && read_ff != commit_ff) begin
                     // ring full of unread bytes: drop the packet
                     addr_wait_in = 1'b1;
                  end else begin
                     if (!len_known_ff && wr_ff == wrap_add(commit_ff, (IDX_W+1)'(1))) begin
                        end_in = wrap_add(commit_ff,
                                          (IDX_W+1)'(in_item.char_data[4:0]) + (IDX_W+1)'(2));
                        len_known_in = 1'b1;
                     end
                     ram_we = 1'b1;
                     wr_in  = wrap_add(wr_ff, (IDX_W+1)'(1));
                  end
               end
            end
            KIND_IGNORE: begin
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         commit_ff    <= '0;
         wr_ff        <= '0;
         end_ff       <= '0;
         read_ff      <= '0;
         len_known_ff <= 1'b0;
         sum_ff       <= 8'd0;
         addr_wait_ff <= 1'b1;
         poll_ff      <= 1'b0;
         bcast_ff     <= 1'b0;
         err_ff       <= 3'd0;
         s1_valid_ff  <= 1'b0;
      end else begin
         commit_ff    <= commit_in;
         wr_ff        <= wr_in;
         end_ff       <= end_in;
         read_ff      <= read_in;
         len_known_ff <= len_known_in;
         sum_ff       <= sum_in;
         addr_wait_ff <= addr_wait_in;
         poll_ff      <= poll_in;
         bcast_ff     <= bcast_in;
         err_ff       <= err_in;
         if (advance) begin
            s1_valid_ff <= in_valid;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         s1_reply_ff  <= reply_in;
         s1_commit_ff <= committed_in;
         s1_rvalid_ff <= rvalid_in;
         s1_err_ff    <= err_in;
         s1_bcast_ff  <= bcast_in;
      end
   end

   // read port fires only on pop, so its output holds while the result waits
   mpr_ram #(
      .WIDTH (8),
      .DEPTH (RING_DEPTH)
   ) u_ring (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_wa),
      .wr_data (in_item.char_data),
      .rd_en   (pop),
      .rd_addr (read_ff),
      .rd_data (ram_q)
   );

   assign out_valid                   = s1_valid_ff;
   assign out_result.reply_kind       = s1_reply_ff;
   assign out_result.packet_committed = s1_commit_ff;
   assign out_result.read_data        = ram_q & {8{s1_rvalid_ff}};
   assign out_result.read_valid       = s1_rvalid_ff;
   assign out_result.status_overrun   = s1_err_ff[0];
   assign out_result.status_framing   = s1_err_ff[1];
   assign out_result.status_checksum  = s1_err_ff[2];
   assign out_result.is_broadcast     = s1_bcast_ff;

endmodule

### src/multidrop_packet_receiver.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// multidrop_packet_receiver
// 9-bit multidrop bus packet receiver with ring buffer and read-out
// ----------------------------------------------------------------------------
// One response transaction per request transaction. The block sustains one
// transaction per clock while rsp_tready stays high: a two-entry queue holds
// classified requests, the packet state machine retires one per cycle unless
// the result register is stalled, with at most one ring write and one ring
// read, and a request passes through its queue entry and then the result
// register before its response is valid. The ring is a registered-read ram
// of RING_DEPTH bytes and needs no clearing after reset.
// csr writes are meant for idle periods only.
module multidrop_packet_receiver #(
   parameter int RING_DEPTH = 128
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   // [7:0] char_data, [8] address_bit, [9] overrun_error, [10] framing_error,
   // [11] tx_packet_ready, [15:12] zero
   input  logic [mpr_pkg::REQ_DATA_W-1:0]     req_tdata,
   // [0] operation
   input  logic                               req_tuser,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // [2:0] reply_kind, [3] packet_committed, [11:4] read_data, [12] read_valid,
   // [13] status_overrun, [14] status_framing, [15] status_checksum,
   // [16] is_broadcast, [23:17] zero
   output logic [mpr_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   input  logic                               csr_we,
   input  logic [mpr_pkg::CSR_ADDR_W-1:0]     csr_addr,
   input  logic [6:0]                         csr_wdata
);

   import mpr_pkg::*;

   logic       [6:0] device_id_ff;
   logic             rx_enable_ff;
   logic             q_valid;
   logic             q_ready;
   item_type         q_item;
   result_type       result;

   always_ff @(posedge clock) begin
      if (reset) begin
         device_id_ff <= 7'd0;
         rx_enable_ff <= 1'b1;
      end else if (csr_we) begin
         unique case (csr_addr)
            CSR_DEVICE_ID: device_id_ff <= csr_wdata;
            CSR_RX_ENABLE: rx_enable_ff <= csr_wdata[0];
            default: begin
            end
         endcase
      end
   end

   mpr_front u_front (
      .clock        (clock),
      .reset        (reset),
      .in_valid     (req_tvalid),
      .in_ready     (req_tready),
      .in_operation (req_tuser),
      .in_data      (req_tdata),
      .device_id    (device_id_ff),
      .rx_enable    (rx_enable_ff),
      .out_valid    (q_valid),
      .out_ready    (q_ready),
      .out_item     (q_item)
   );

   mpr_back #(
      .RING_DEPTH (RING_DEPTH)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (q_valid),
      .in_ready   (q_ready),
      .in_item    (q_item),
      .out_valid  (rsp_tvalid),
      .out_ready  (rsp_tready),
      .out_result (result)
   );

   assign rsp_tdata = {7'd0, result.is_broadcast, result.status_checksum,
                       result.status_framing, result.status_overrun,
                       result.read_valid, result.read_data,
                       result.packet_committed, result.reply_kind};

endmodule

### src/mpr_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mpr_checker
// port-level checks on the response channel of the packet receiver
// ----------------------------------------------------------------------------
`include "multidrop_packet_receiver_macros.svh"

module mpr_checker (
   input logic                           clock,
   input logic                           reset,
   input logic                           rsp_tvalid,
   input logic                           rsp_tready,
   input logic [mpr_pkg::RSP_DATA_W-1:0] rsp_tdata
);

   import mpr_pkg::*;

   logic rsp_take;
   logic ovr_seen_ff;
   logic chk_seen_ff;

   assign rsp_take = rsp_tvalid && rsp_tready;

   // error flags are sticky across responses
   always_ff @(posedge clock) begin
      if (reset) begin
         ovr_seen_ff <= 1'b0;
         chk_seen_ff <= 1'b0;
      end else if (rsp_take) begin
         ovr_seen_ff <= ovr_seen_ff || rsp_tdata[13];
         chk_seen_ff <= chk_seen_ff || rsp_tdata[15];
      end
   end

   `MPR_ASSERT_NXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready,
                   rsp_tvalid && $stable(rsp_tdata))
   `MPR_ASSERT_IMP(a_commit_reply, clock, reset, rsp_tvalid && rsp_tdata[3],
                   rsp_tdata[2:0] == REPLY_ACK || rsp_tdata[2:0] == REPLY_NONE)
   `MPR_ASSERT_IMP(a_read_quiet, clock, reset, rsp_tvalid && rsp_tdata[12],
                   rsp_tdata[2:0] == REPLY_NONE && !rsp_tdata[3])
   `MPR_ASSERT_IMP(a_empty_read, clock, reset, rsp_tvalid && !rsp_tdata[12],
                   rsp_tdata[11:4] == 8'd0)
   `MPR_ASSERT_IMP(a_sticky, clock, reset, rsp_tvalid,
                   (!ovr_seen_ff || rsp_tdata[13]) && (!chk_seen_ff || rsp_tdata[15]))

endmodule

bind multidrop_packet_receiver mpr_checker u_mpr_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
